/* sv/ffba_pkg.sv */
// ffba_pkg: shared types and constants of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int ADDR_W = 32;
  localparam int REQ_W  = 17;
  localparam int HDR_W  = 17;
  localparam int OFS_W  = 18;
  localparam int LEN_W  = 17;

  localparam logic [LEN_W-1:0] HEAP_LENGTH_RST = 17'h10000;
  localparam logic             FREE_MARK       = 1'b1;
  localparam logic [2:0]       ROUND_ADD       = 3'd3;
  localparam logic [2:0]       HDR_BYTES       = 3'd4;

  localparam logic CFG_HEAP_BASE   = 1'b0;
  localparam logic CFG_HEAP_LENGTH = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] release_address;
  } ffba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    logic              status;
  } ffba_out_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [2:0]        k;
    logic [ADDR_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] res;
    logic              lt;
    logic              eq;
  } alu_rsp_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

/* sv/ffba_alu.sv */
// ffba_alu: shared adder/comparator, res = a +/- b +/- k, flags res vs c.
// Depends on ffba_pkg.
module ffba_alu (
  input  ffba_pkg::alu_req_t req,
  output ffba_pkg::alu_rsp_t rsp
);

  logic [ffba_pkg::ADDR_W-1:0] res;

  always_comb begin
    unique case (req.op)
      ffba_pkg::ALU_ADD: res = req.a + req.b + 32'(req.k);
      ffba_pkg::ALU_SUB: res = req.a - req.b - 32'(req.k);
      default:           res = '0;
    endcase
  end

  assign rsp.res = res;
  assign rsp.lt  = (res < req.c);
  assign rsp.eq  = (res == req.c);

endmodule

/* sv/ffba_hdr_mem.sv */
// ffba_hdr_mem: single-port header store, registered read.
// Depends on ffba_pkg.
module ffba_hdr_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                         clk,
  input  ffba_pkg::mem_ctl_t           ctl,
  input  logic [AW-1:0]                addr,
  input  logic [ffba_pkg::HDR_W-1:0]   wdata,
  output logic [ffba_pkg::HDR_W-1:0]   rdata
);

  logic [ffba_pkg::HDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/ffba_ctrl.sv */
// ffba_ctrl: sequencer, config registers, bump pointer and result register.
// Depends on ffba_pkg; drives ffba_alu and ffba_hdr_mem.
module ffba_ctrl #(
  parameter int HEAP_WORDS = 16384,
  parameter int AW         = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ffba_pkg::ffba_in_t             in_req,
  output logic                           out_strobe,
  output ffba_pkg::ffba_out_t            out_result,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]    cfg_wdata,
  output ffba_pkg::alu_req_t             alu_req,
  input  ffba_pkg::alu_rsp_t             alu_rsp,
  output ffba_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                  mem_addr,
  output logic [ffba_pkg::HDR_W-1:0]     mem_wdata,
  input  logic [ffba_pkg::HDR_W-1:0]     mem_rdata
);

  localparam int CAP_W = 23;
  localparam logic [CAP_W-1:0] CAP_BYTES = CAP_W'(HEAP_WORDS * 4);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_ROUND = 12'b000000000010,
    S_BUMP  = 12'b000000000100,
    S_WCHK  = 12'b000000001000,
    S_WRD   = 12'b000000010000,
    S_WNEXT = 12'b000000100000,
    S_SPLIT = 12'b000001000000,
    S_REM   = 12'b000010000000,
    S_ADDR  = 12'b000100000000,
    S_FOFF  = 12'b001000000000,
    S_FCHK  = 12'b010000000000,
    S_FRD   = 12'b100000000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ffba_pkg::LEN_W-1:0]      bump_r, bump_nxt;
  logic [ffba_pkg::ADDR_W-1:0]     base_r;
  logic [ffba_pkg::LEN_W-1:0]      len_r;
  logic                            strobe_r, strobe_nxt;
  ffba_pkg::ffba_out_t             result_r, result_nxt;
  logic [ffba_pkg::OFS_W-1:0]      req_r, req_nxt;
  logic [ffba_pkg::ADDR_W-1:0]     rel_r, rel_nxt;
  logic [ffba_pkg::OFS_W-1:0]      off_r, off_nxt;
  logic [ffba_pkg::ADDR_W-1:0]     tmp_r, tmp_nxt;
  logic [ffba_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  logic                            exact_r, exact_nxt;
  logic [ffba_pkg::HDR_W-1:0]      lm4_r, lm4_nxt;

  logic [ffba_pkg::LEN_W-1:0]      len_clip;
  logic [ffba_pkg::LEN_W-1:0]      eff_len;

  function automatic logic [AW-1:0] word_of(input logic [ffba_pkg::OFS_W-1:0] ofs);
    return AW'(ofs[ffba_pkg::OFS_W-1:2]);
  endfunction

  function automatic logic in_rng(input logic [ffba_pkg::OFS_W-1:0] ofs);
    return (32'(ofs[ffba_pkg::OFS_W-1:2]) < 32'(HEAP_WORDS));
  endfunction

  assign len_clip = ({6'b0, len_r} > CAP_BYTES) ? CAP_BYTES[ffba_pkg::LEN_W-1:0] : len_r;
  assign eff_len  = {len_clip[ffba_pkg::LEN_W-1:2], 2'b00};

  always_comb begin
    state_nxt  = state_r;
    bump_nxt   = bump_r;
    strobe_nxt = 1'b0;
    result_nxt = result_r;
    req_nxt    = req_r;
    rel_nxt    = rel_r;
    off_nxt    = off_r;
    tmp_nxt    = tmp_r;
    hdr_nxt    = hdr_r;
    exact_nxt  = exact_r;
    lm4_nxt    = lm4_r;
    alu_req    = '{op: ffba_pkg::ALU_ADD, a: '0, b: '0, k: '0, c: '0};
    mem_ctl    = '{rd: 1'b0, wr: 1'b0};
    mem_addr   = '0;
    mem_wdata  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = {1'b0, in_req.request_bytes};
          rel_nxt   = in_req.release_address;
          state_nxt = (in_req.operation == ffba_pkg::OP_FREE) ? S_FOFF : S_ROUND;
        end
      end
      S_ROUND: begin
        alu_req.a = 32'(req_r);
        alu_req.k = ffba_pkg::ROUND_ADD;
        req_nxt   = {alu_rsp.res[ffba_pkg::OFS_W-1:2], 2'b00};
        state_nxt = S_BUMP;
      end
      S_BUMP: begin
        alu_req.a = 32'(bump_r);
        alu_req.b = 32'(req_r);
        alu_req.k = ffba_pkg::HDR_BYTES;
        alu_req.c = 32'(eff_len);
        if (alu_rsp.lt || alu_rsp.eq) begin
          mem_ctl.wr = in_rng({1'b0, bump_r});
          mem_addr   = word_of({1'b0, bump_r});
          mem_wdata  = req_r[ffba_pkg::HDR_W-1:0];
          off_nxt    = {1'b0, bump_r};
          bump_nxt   = alu_rsp.res[ffba_pkg::LEN_W-1:0];
          state_nxt  = S_ADDR;
        end else begin
          off_nxt   = '0;
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        alu_req.a = 32'(off_r);
        alu_req.c = 32'(bump_r);
        if (alu_rsp.lt && in_rng(off_r)) begin
          mem_ctl.rd = 1'b1;
          mem_addr   = word_of(off_r);
          state_nxt  = S_WRD;
        end else begin
          result_nxt = '{payload_address: '0, status: ffba_pkg::ST_FAIL};
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WRD: begin
        hdr_nxt   = mem_rdata;
        alu_req.a = 32'({mem_rdata[ffba_pkg::HDR_W-1:1], 1'b0});
        alu_req.c = 32'(req_r);
        exact_nxt = alu_rsp.eq;
        if ((mem_rdata[0] == ffba_pkg::FREE_MARK) && !alu_rsp.lt) begin
          state_nxt = S_SPLIT;
        end else begin
          state_nxt = S_WNEXT;
        end
      end
      S_WNEXT: begin
        alu_req.a = 32'(off_r);
        alu_req.b = 32'({hdr_r[ffba_pkg::HDR_W-1:1], 1'b0});
        alu_req.k = ffba_pkg::HDR_BYTES;
        off_nxt   = alu_rsp.res[ffba_pkg::OFS_W-1:0];
        state_nxt = S_WCHK;
      end
      S_SPLIT: begin
        mem_ctl.wr = 1'b1;
        mem_addr   = word_of(off_r);
        mem_wdata  = req_r[ffba_pkg::HDR_W-1:0];
        alu_req.op = ffba_pkg::ALU_SUB;
        alu_req.a  = 32'({hdr_r[ffba_pkg::HDR_W-1:1], 1'b0});
        alu_req.b  = 32'(req_r);
        alu_req.k  = ffba_pkg::HDR_BYTES;
        lm4_nxt    = alu_rsp.res[ffba_pkg::HDR_W-1:0];
        state_nxt  = exact_r ? S_ADDR : S_REM;
      end
      S_REM: begin
        alu_req.a  = 32'(off_r);
        alu_req.b  = 32'(req_r);
        alu_req.k  = ffba_pkg::HDR_BYTES;
        mem_ctl.wr = in_rng(alu_rsp.res[ffba_pkg::OFS_W-1:0]);
        mem_addr   = word_of(alu_rsp.res[ffba_pkg::OFS_W-1:0]);
        mem_wdata  = {lm4_r[ffba_pkg::HDR_W-1:1], ffba_pkg::FREE_MARK};
        state_nxt  = S_ADDR;
      end
      S_ADDR: begin
        alu_req.a  = base_r;
        alu_req.b  = 32'(off_r);
        alu_req.k  = ffba_pkg::HDR_BYTES;
        result_nxt = '{payload_address: alu_rsp.res, status: ffba_pkg::ST_OK};
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FOFF: begin
        alu_req.op = ffba_pkg::ALU_SUB;
        alu_req.a  = rel_r;
        alu_req.b  = base_r;
        alu_req.k  = ffba_pkg::HDR_BYTES;
        tmp_nxt    = alu_rsp.res;
        state_nxt  = S_FCHK;
      end
      S_FCHK: begin
        alu_req.a = tmp_r;
        alu_req.c = 32'(bump_r);
        if (alu_rsp.lt && (tmp_r[1:0] == 2'b00)) begin
          mem_ctl.rd = 1'b1;
          mem_addr   = word_of(tmp_r[ffba_pkg::OFS_W-1:0]);
          state_nxt  = S_FRD;
        end else begin
          result_nxt = '{payload_address: '0, status: ffba_pkg::ST_OK};
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FRD: begin
        mem_ctl.wr = 1'b1;
        mem_addr   = word_of(tmp_r[ffba_pkg::OFS_W-1:0]);
        mem_wdata  = {mem_rdata[ffba_pkg::HDR_W-1:1], ffba_pkg::FREE_MARK};
        result_nxt = '{payload_address: '0, status: ffba_pkg::ST_OK};
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bump_r   <= '0;
      strobe_r <= 1'b0;
      base_r   <= '0;
      len_r    <= ffba_pkg::HEAP_LENGTH_RST;
    end else begin
      state_r  <= state_nxt;
      bump_r   <= bump_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ffba_pkg::CFG_HEAP_BASE:   base_r <= cfg_wdata;
          ffba_pkg::CFG_HEAP_LENGTH: len_r  <= cfg_wdata[ffba_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    req_r    <= req_nxt;
    rel_r    <= rel_nxt;
    off_r    <= off_nxt;
    tmp_r    <= tmp_nxt;
    hdr_r    <= hdr_nxt;
    exact_r  <= exact_nxt;
    lm4_r    <= lm4_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_result = result_r;

endmodule

/* sv/first_fit_block_allocator.sv */
// first_fit_block_allocator: top level, sequencer plus shared ALU plus header store.
// Depends on ffba_pkg, ffba_ctrl, ffba_alu, ffba_hdr_mem.
//
//   channel | ports                          | handshake
//   request | start, busy, in_req            | taken when start && !busy
//   result  | out_strobe, out_result         | one-cycle strobe, no back-pressure
//   config  | cfg_we, cfg_index, cfg_wdata   | written when cfg_we
//
// Bump allocate: S_ROUND, S_BUMP, S_ADDR; free: S_FOFF, S_FCHK, S_FRD for a valid header;
// result strobes the cycle after. First-fit walk: S_WCHK, S_WRD, S_WNEXT per header passed
// over (one store read each); hit: S_SPLIT, S_REM if split, S_ADDR; miss ends at S_WCHK.
// Reset zeroes the bump pointer and restores register defaults; header store is not cleared.
// The receiver cannot stall; only the sequencer holds busy.
module first_fit_block_allocator #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ffba_pkg::ffba_in_t          in_req,
  output logic                        out_strobe,
  output ffba_pkg::ffba_out_t         out_result,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(HEAP_WORDS);

  ffba_pkg::alu_req_t          alu_req;
  ffba_pkg::alu_rsp_t          alu_rsp;
  ffba_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]               mem_addr;
  logic [ffba_pkg::HDR_W-1:0]  mem_wdata;
  logic [ffba_pkg::HDR_W-1:0]  mem_rdata;

  ffba_ctrl #(
    .HEAP_WORDS(HEAP_WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  ffba_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  ffba_hdr_mem #(
    .DEPTH(HEAP_WORDS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

/* sv/ffba_chk.sv */
// ffba_chk: port-level checks of the allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ffba_pkg::ffba_out_t out_result,
  input logic                out_strobe
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("request finished without result");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_result.status == ffba_pkg::ST_FAIL) |->
      (out_result.payload_address == '0))
    else $error("failed allocate returned nonzero address");

endmodule

bind first_fit_block_allocator ffba_chk u_chk (.*);

/* bench/alloc_checker.sv */
`timescale 1ns / 100ps
// alloc_checker: watches the request, result and register ports of the allocator,
// keeps its own copy of headers, bump pointer and settings, and checks results in order.
// Depends on ffba_pkg.
module alloc_checker #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  ffba_pkg::ffba_in_t          in_req,
  input  logic                        out_strobe,
  input  ffba_pkg::ffba_out_t         out_result,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0] cfg_wdata,
  output int                          mismatch_count
);
  import ffba_pkg::*;

  logic [ADDR_W-1:0] heap_base;
  logic [LEN_W-1:0]  heap_length;
  logic [REQ_W-1:0]  bump_offset;
  logic [HDR_W-1:0]  header_words [HEAP_WORDS];
  ffba_out_t         predicted_results [$];
  ffba_out_t         awaited;

  initial begin
    for (int i = 0; i < HEAP_WORDS; i++) header_words[i] = '0;
  end

  function automatic logic [HDR_W-1:0] read_header(logic [31:0] ofs);
    if ((ofs >> 2) >= HEAP_WORDS) return '0;
    return header_words[ofs >> 2];
  endfunction

  function automatic void write_header(logic [31:0] ofs, logic [HDR_W-1:0] val);
    if ((ofs >> 2) < HEAP_WORDS) header_words[ofs >> 2] = val;
  endfunction

  function automatic logic [31:0] usable_bytes();
    logic [31:0] cap;
    logic [31:0] len;
    cap = HEAP_WORDS * 4;
    len = (32'(heap_length) > cap) ? cap : 32'(heap_length);
    return {len[31:2], 2'b00};
  endfunction

  function automatic ffba_out_t allocate_or_free(ffba_in_t rq);
    ffba_out_t        res;
    logic [31:0]      ofs;
    logic [31:0]      want;
    logic [31:0]      blk_size;
    logic [31:0]      left;
    logic [HDR_W-1:0] hdr;
    res = '0;
    res.status = ST_OK;
    if (rq.operation == OP_FREE) begin
      ofs = rq.release_address - heap_base - HDR_BYTES;
      if (ofs[1:0] == 2'b00 && ofs < 32'(bump_offset))
        write_header(ofs, read_header(ofs) | FREE_MARK);
      return res;
    end
    want = {15'd0, rq.request_bytes} + ROUND_ADD;
    want[1:0] = 2'b00;
    if (32'(bump_offset) + HDR_BYTES + want <= usable_bytes()) begin
      ofs = 32'(bump_offset);
      write_header(ofs, want[HDR_W-1:0]);
      bump_offset = REQ_W'(ofs + HDR_BYTES + want);
      res.payload_address = heap_base + ofs + HDR_BYTES;
      return res;
    end
    // first fit, headers in address order up to the bump pointer
    ofs = '0;
    while (ofs < 32'(bump_offset) && (ofs >> 2) < HEAP_WORDS) begin
      hdr = read_header(ofs);
      blk_size = {15'd0, hdr[HDR_W-1:1], 1'b0};
      if (hdr[0] == FREE_MARK && blk_size >= want) begin
        left = blk_size - want;
        write_header(ofs, want[HDR_W-1:0]);
        if (left != 0)
          write_header(ofs + HDR_BYTES + want, (left[HDR_W-1:0] - HDR_BYTES) | FREE_MARK);
        res.payload_address = heap_base + ofs + HDR_BYTES;
        return res;
      end
      ofs = ofs + HDR_BYTES + blk_size;
    end
    res.status = ST_FAIL;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      heap_base = '0;
      heap_length = HEAP_LENGTH_RST;
      bump_offset = '0;
      predicted_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_strobe) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with no request open, expected none, got %h / %0d",
                   $time, out_result.payload_address, out_result.status);
          mismatch_count++;
        end else begin
          awaited = predicted_results.pop_front();
          if (out_result.payload_address !== awaited.payload_address) begin
            $display("%0t: payload_address expected %h, got %h",
                     $time, awaited.payload_address, out_result.payload_address);
            mismatch_count++;
          end
          if (out_result.status !== awaited.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, awaited.status, out_result.status);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) heap_base = cfg_wdata;
        else heap_length = cfg_wdata[LEN_W-1:0];
      end
      if (start && !busy) predicted_results.push_back(allocate_or_free(in_req));
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// testbench: clock, reset, register settings and request stimulus for the allocator,
// with the checker beside it. Depends on ffba_pkg, alloc_checker, first_fit_block_allocator.
module testbench;
  import ffba_pkg::*;

  localparam int HEAP_WORDS  = 16384;
  localparam int DRAIN_LIMIT = 100000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ffba_in_t            in_req;
  logic                out_strobe;
  ffba_out_t           out_result;
  logic                cfg_we;
  logic                cfg_index;
  logic [ADDR_W-1:0]   cfg_wdata;
  int                  mismatch_count;

  logic                issued_ops [$];
  logic [31:0]         issued_sizes [$];
  logic [31:0]         live_hdrs [$];
  logic [31:0]         cur_base;
  logic [31:0]         frontier;
  logic                done_op;
  logic [31:0]         done_size;
  logic [31:0]         done_hdr;
  bit                  gaps_now;
  int                  gap_mode_left;

  first_fit_block_allocator #(.HEAP_WORDS(HEAP_WORDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  alloc_checker #(.HEAP_WORDS(HEAP_WORDS)) alloc_watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_strobe     (out_strobe),
    .out_result     (out_result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Mismatches found");
    $finish;
  end

  // headers handed out so far feed well-formed frees
  always @(posedge clk) begin
    if (rst_n && out_strobe && issued_ops.size() != 0) begin
      done_op   = issued_ops.pop_front();
      done_size = issued_sizes.pop_front();
      done_hdr  = out_result.payload_address - cur_base - HDR_BYTES;
      if (done_op == OP_ALLOC && out_result.status == ST_OK &&
          done_hdr[1:0] == 2'b00 && done_hdr < HEAP_WORDS * 4) begin
        live_hdrs.push_back(done_hdr);
        if (done_hdr + HDR_BYTES + done_size > frontier)
          frontier = done_hdr + HDR_BYTES + done_size;
      end
    end
  end

  function automatic logic [REQ_W-1:0] pick_bytes();
    case ($urandom_range(0, 39))
      0:       return REQ_W'($urandom_range(0, 65536));
      1, 2, 3: return REQ_W'($urandom_range(0, 1024));
      default: return REQ_W'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic ffba_in_t make_alloc(logic [REQ_W-1:0] nbytes);
    ffba_in_t rq;
    rq.operation       = OP_ALLOC;
    rq.request_bytes   = nbytes;
    rq.release_address = $urandom;
    return rq;
  endfunction

  function automatic ffba_in_t make_free(logic [31:0] addr);
    ffba_in_t rq;
    rq.operation       = OP_FREE;
    rq.request_bytes   = REQ_W'($urandom_range(0, 65536));
    rq.release_address = addr;
    return rq;
  endfunction

  function automatic ffba_in_t random_request();
    ffba_in_t    rq;
    int unsigned pick;
    int unsigned idx;
    logic [31:0] rel;
    logic [31:0] ofs;
    rq = make_alloc(pick_bytes());
    pick = $urandom_range(0, 99);
    if (pick < 40 && live_hdrs.size() != 0) begin
      idx = $urandom_range(0, live_hdrs.size() - 1);
      rq = make_free(cur_base + live_hdrs[idx] + HDR_BYTES);
      if ($urandom_range(0, 3) != 0) live_hdrs.delete(idx);
    end else if (pick < 48) begin
      case (pick % 3)
        0:       rel = cur_base + frontier + HDR_BYTES;
        1:       rel = cur_base + ($urandom_range(0, 16383) << 2) + 2;
        default: rel = $urandom;
      endcase
      // never touch a word below the bump pointer that holds no header
      ofs = rel - cur_base - HDR_BYTES;
      if (ofs != frontier && ofs[1:0] == 2'b00 && ofs < HEAP_WORDS * 4) rel[0] = ~rel[0];
      rq = make_free(rel);
    end
    return rq;
  endfunction

  task automatic issue(input ffba_in_t rq);
    logic [31:0] want;
    want = {15'd0, rq.request_bytes} + ROUND_ADD;
    want[1:0] = 2'b00;
    start  <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued_ops.push_back(rq.operation);
    issued_sizes.push_back(want);
  endtask

  task automatic maybe_pause(input bit allow);
    if (gap_mode_left == 0) begin
      gaps_now = !gaps_now;
      gap_mode_left = $urandom_range(10, 50);
    end
    gap_mode_left--;
    if (allow && gaps_now && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send(input ffba_in_t rq);
    issue(rq);
    maybe_pause(1'b1);
  endtask

  task automatic run_phase(input int n, input bit allow_gaps);
    repeat (n) begin
      issue(random_request());
      maybe_pause(allow_gaps);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (issued_ops.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (issued_ops.size() != 0) begin
      $display("%0t: results still outstanding", $time);
      $display("Mismatches found");
      $finish;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAP_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_HEAP_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_base  = base;
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req        = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HEAP_BASE;
    cfg_wdata     = '0;
    cur_base      = '0;
    frontier      = '0;
    gaps_now      = 1'b1;
    gap_mode_left = $urandom_range(10, 50);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings out of reset, nothing allocated yet
    send(make_alloc(17'h10000));
    send(make_alloc(17'hFFFF));
    send(make_free(32'd0));
    drain();

    // tiny heap just below the address wrap
    configure(32'hFFFF_FFF0, 32'd40);
    send(make_alloc(17'd0));
    send(make_alloc(17'd1));
    send(make_alloc(17'd7));
    send(make_alloc(17'd12));
    send(make_alloc(17'd0));
    send(make_free(cur_base + 32'd16));
    send(make_free(cur_base + 32'd17));
    send(make_free(cur_base + 32'd44));
    send(make_free(cur_base));
    send(make_alloc(17'd4));
    send(make_alloc(17'd0));
    send(make_free(cur_base + 32'd28));
    send(make_free(cur_base + 32'd28));
    send(make_alloc(17'd12));
    send(make_free(cur_base + 32'd28));
    send(make_alloc(17'd8));
    send(make_alloc(17'h10000));
    send(make_free(cur_base + 32'd4));
    send(make_alloc(17'd0));
    drain();
    configure(32'hFFFF_FFF0, 32'd0);
    send(make_alloc(17'd0));
    send(make_alloc(17'd4));
    drain();

    configure($urandom_range(0, 32'hFFFF_FFFC), 32'd256);
    run_phase(250, 1'b1);
    drain();
    configure($urandom_range(0, 32'hFFFF_FFFC), 32'd1024);
    run_phase(300, 1'b1);
    drain();
    configure(32'd0, 32'd100);
    run_phase(230, 1'b1);
    drain();
    configure(32'hFFFF_FFFC, 32'd65535);
    run_phase(300, 1'b1);
    drain();
    configure($urandom_range(0, 32'hFFFF_FFFC), 32'd65536);
    run_phase(200, 1'b1);
    run_phase(130, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ffba_pkg.sv
sv/ffba_alu.sv
sv/ffba_hdr_mem.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator.sv
sv/ffba_chk.sv
bench/alloc_checker.sv
bench/testbench.sv
